### rtl/samdu_pkg.sv
// ----------------------------------------------------------------------------
// samdu_pkg: shared types and constants of the shift-add multiply/divide unit
// Opcode codes and default operand width.
// ----------------------------------------------------------------------------
package samdu_pkg;

  localparam int unsigned DefWidth = 16;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_RDIV = 2'd1,
    OP_NDIV = 2'd2,
    OP_NONE = 2'd3
  } op_t;

endpackage

### rtl/shift_add_multiply_divide_unit.sv
// ----------------------------------------------------------------------------
// shift_add_multiply_divide_unit: pipelined Booth multiplier and divider
// One request per cycle; WIDTH step stages plus an output stage.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high; busy is always low, so a new
// request may be issued every clock. Each request yields one result, shown on
// out_result_low/out_result_high for one cycle with out_valid high. The
// first step register loads on the edge that took the request, and WIDTH-1
// further step registers plus the output stage (which applies the
// non-restoring remainder fix-up) follow before out_valid rises.
// Results leave in request order. The receiver cannot stall, and none
// needs to be held off. Opcode 0: signed Booth product (low/high halves).
// Opcodes 1 and 2: unsigned quotient (low) and remainder (high); a zero
// divisor gives a quotient of all ones and the dividend as remainder. Opcode
// 3 gives zeros. Operands are taken as their low WIDTH bits.
module shift_add_multiply_divide_unit #(
  parameter int unsigned WIDTH = samdu_pkg::DefWidth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  output logic        out_valid,
  output logic [15:0] out_result_low,
  output logic [15:0] out_result_high
);
  import samdu_pkg::*;

  // pipeline taps; tap 0 is the request itself
  logic             vld  [WIDTH+1];
  op_t              op   [WIDTH+1];
  logic [WIDTH:0]   acc  [WIDTH+1];
  logic [WIDTH-1:0] mq   [WIDTH+1];
  logic             prev [WIDTH+1];
  logic [WIDTH-1:0] m    [WIDTH+1];

  assign busy    = 1'b0;
  assign vld[0]  = start;
  assign op[0]   = op_t'(in_opcode);
  assign acc[0]  = '0;
  assign mq[0]   = WIDTH'(in_operand_a);
  assign prev[0] = 1'b0;
  assign m[0]    = WIDTH'(in_operand_b);

  for (genvar g = 0; g < WIDTH; g++) begin : g_step
    samdu_step #(.WIDTH(WIDTH)) u_step (
      .clk, .rst_n,
      .in_vld(vld[g]), .in_op(op[g]), .in_acc(acc[g]), .in_mq(mq[g]),
      .in_prev(prev[g]), .in_m(m[g]),
      .out_vld(vld[g+1]), .out_op(op[g+1]), .out_acc(acc[g+1]),
      .out_mq(mq[g+1]), .out_prev(prev[g+1]), .out_m(m[g+1])
    );
  end

  // output stage: non-restoring fix-up and zeroing of the unused opcode
  logic             valid_r;
  logic [WIDTH-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [WIDTH:0]   fix;

  always_comb begin
    fix    = acc[WIDTH] + {1'b0, m[WIDTH]};
    lo_nxt = mq[WIDTH];
    hi_nxt = acc[WIDTH][WIDTH-1:0];
    if (op[WIDTH] == OP_NDIV && acc[WIDTH][WIDTH]) hi_nxt = fix[WIDTH-1:0];
    if (op[WIDTH] == OP_NONE) begin
      lo_nxt = '0;
      hi_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= vld[WIDTH];
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign out_valid       = valid_r;
  assign out_result_low  = 16'(lo_r);
  assign out_result_high = 16'(hi_r);

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    vld[WIDTH] |=> out_valid) else $error("result lost");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    (vld[WIDTH] && op[WIDTH] == OP_NONE) |=> (out_result_low == '0 && out_result_high == '0))
    else $error("unused opcode not zero");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule

### rtl/samdu_step.sv
// ----------------------------------------------------------------------------
// samdu_step: one registered shift-add iteration
// Performs one Booth, restoring or non-restoring step and registers the result.
// ----------------------------------------------------------------------------
module samdu_step #(
  parameter int unsigned WIDTH = samdu_pkg::DefWidth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  samdu_pkg::op_t         in_op,
  input  logic [WIDTH:0]         in_acc,
  input  logic [WIDTH-1:0]       in_mq,
  input  logic                   in_prev,
  input  logic [WIDTH-1:0]       in_m,
  output logic                   out_vld,
  output samdu_pkg::op_t         out_op,
  output logic [WIDTH:0]         out_acc,
  output logic [WIDTH-1:0]       out_mq,
  output logic                   out_prev,
  output logic [WIDTH-1:0]       out_m
);
  import samdu_pkg::*;

  logic             vld_r;
  op_t              op_r;
  logic [WIDTH:0]   acc_r, acc_nxt, msx, mzx, t, sh;
  logic [WIDTH-1:0] mq_r, mq_nxt, sq;
  logic             prev_r, prev_nxt;
  logic [WIDTH-1:0] m_r;

  always_comb begin
    msx      = {in_m[WIDTH-1], in_m};
    mzx      = {1'b0, in_m};
    acc_nxt  = in_acc;
    mq_nxt   = in_mq;
    prev_nxt = in_prev;
    sh       = {in_acc[WIDTH-1:0], in_mq[WIDTH-1]};
    sq       = {in_mq[WIDTH-2:0], 1'b0};
    t        = in_acc;
    unique case (in_op)
      OP_MUL: begin
        if (in_mq[0] && !in_prev) t = in_acc - msx;
        else if (!in_mq[0] && in_prev) t = in_acc + msx;
        prev_nxt = in_mq[0];
        mq_nxt   = {t[0], in_mq[WIDTH-1:1]};
        acc_nxt  = {t[WIDTH], t[WIDTH:1]};
      end
      OP_RDIV: begin
        t = sh - mzx;
        if (t[WIDTH]) begin
          acc_nxt = sh;
          mq_nxt  = sq;
        end else begin
          acc_nxt = t;
          mq_nxt  = {sq[WIDTH-1:1], 1'b1};
        end
      end
      OP_NDIV: begin
        t       = in_acc[WIDTH] ? (sh + mzx) : (sh - mzx);
        acc_nxt = t;
        mq_nxt  = {sq[WIDTH-1:1], ~t[WIDTH]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld;
    op_r   <= in_op;
    acc_r  <= acc_nxt;
    mq_r   <= mq_nxt;
    prev_r <= prev_nxt;
    m_r    <= in_m;
  end

  assign out_vld  = vld_r;
  assign out_op   = op_r;
  assign out_acc  = acc_r;
  assign out_mq   = mq_r;
  assign out_prev = prev_r;
  assign out_m    = m_r;
endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the shift-add multiply/divide unit
// A directed table of requests (extremes, each opcode, zero divisor, most
// negative multiplicand, unused opcode) followed by random requests with
// random gaps. Every result is checked against a typed-in value or a behavioral predictor.
// ----------------------------------------------------------------------------
module tb;
  import samdu_pkg::*;

  localparam int unsigned Width      = 16;
  localparam int          NumRandom  = 1420;
  localparam int          Latency    = Width + 1;
  localparam int          CycleLimit = 200000;

  typedef struct {
    op_t         opcode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        has_expected;   // expected result typed into the table
    logic [15:0] exp_low;
    logic [15:0] exp_high;
  } request_row_t;

  typedef struct {
    logic [15:0] res_low;
    logic [15:0] res_high;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [15:0] in_operand_a;
  logic [15:0] in_operand_b;
  logic        out_valid;
  logic [15:0] out_result_low;
  logic [15:0] out_result_high;

  shift_add_multiply_divide_unit #(.WIDTH(Width)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_operand_a    (in_operand_a),
    .in_operand_b    (in_operand_b),
    .out_valid       (out_valid),
    .out_result_low  (out_result_low),
    .out_result_high (out_result_high)
  );

  // Expected results, oldest first.
  result_t pending_results[$];
  int      mismatch_count;
  int      cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute the result of one request. Multiply uses the signed product of
  // the two operands; the divides give the unsigned quotient/remainder, with
  // a zero divisor giving all ones and the dividend. Opcode 3 gives zeros.
  function automatic result_t compute_result(op_t op, logic [15:0] a, logic [15:0] b);
    result_t        r;
    logic signed [31:0] product;
    product = $signed(a) * $signed(b);
    case (op)
      OP_MUL: begin
        r.res_low  = product[15:0];
        r.res_high = product[31:16];
      end
      OP_RDIV, OP_NDIV: begin
        if (b == 16'd0) begin
          r.res_low  = 16'hFFFF;
          r.res_high = a;
        end else begin
          r.res_low  = a / b;
          r.res_high = a % b;
        end
      end
      default: begin
        r.res_low  = 16'd0;
        r.res_high = 16'd0;
      end
    endcase
    return r;
  endfunction

  // Directed table: expected values typed in only for the obvious rows.
  request_row_t directed_rows[18] = '{
    '{OP_MUL,  16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{OP_MUL,  16'hFFFF, 16'hFFFF, 1'b1, 16'h0001, 16'h0000},
    '{OP_MUL,  16'h8000, 16'h8000, 1'b1, 16'h0000, 16'h4000},
    '{OP_MUL,  16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{OP_MUL,  16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{OP_MUL,  16'h0001, 16'h8000, 1'b1, 16'h8000, 16'hFFFF},
    '{OP_MUL,  16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000},
    '{OP_RDIV, 16'hFFFF, 16'h0000, 1'b1, 16'hFFFF, 16'hFFFF},
    '{OP_NDIV, 16'h1234, 16'h0000, 1'b1, 16'hFFFF, 16'h1234},
    '{OP_RDIV, 16'h0000, 16'h0000, 1'b1, 16'hFFFF, 16'h0000},
    '{OP_RDIV, 16'hFFFF, 16'h0001, 1'b1, 16'hFFFF, 16'h0000},
    '{OP_NDIV, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0001, 16'h0000},
    '{OP_RDIV, 16'h0001, 16'hFFFF, 1'b1, 16'h0000, 16'h0001},
    '{OP_NDIV, 16'h8000, 16'h8001, 1'b1, 16'h0000, 16'h8000},
    '{OP_NDIV, 16'hFFFF, 16'h0007, 1'b0, 16'h0000, 16'h0000},
    '{OP_RDIV, 16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000},
    '{OP_NONE, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 16'h0000},
    '{OP_NONE, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000}
  };

  // Drive one request, hold until accepted, then queue its expectation.
  task automatic issue_request(op_t op, logic [15:0] a, logic [15:0] b,
                               logic typed, logic [15:0] lo, logic [15:0] hi);
    result_t r;
    if (typed) begin
      r.res_low  = lo;
      r.res_high = hi;
    end else begin
      r = compute_result(op, a, b);
    end
    start        <= 1'b1;
    in_opcode    <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.insert(pending_results.size(), r);
  endtask

  // Random gap: mostly none or short, now and then long.
  task automatic idle_gap();
    int n;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) n = 0;
    else if (pick < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(5, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] random_operand();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000 | 16'($urandom_range(0, 3));
      3: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Result monitor: sampled at the edge that ends the strobe cycle.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("tb: unexpected result low=%h high=%h", out_result_low,
                   out_result_high);
      end else begin
        want = pending_results.pop_front();
        if (out_result_low !== want.res_low || out_result_high !== want.res_high) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("tb: mismatch exp low=%h high=%h got low=%h high=%h",
                     want.res_low, want.res_high, out_result_low, out_result_high);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    int   drain;
    op_t  op;
    mismatch_count = 0;
    cycle_count    = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_opcode      = OP_MUL;
    in_operand_a   = 16'd0;
    in_operand_b   = 16'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].opcode, directed_rows[i].operand_a,
                    directed_rows[i].operand_b, directed_rows[i].has_expected,
                    directed_rows[i].exp_low, directed_rows[i].exp_high);
      if (i % 5 == 4) idle_gap();
    end

    for (int k = 0; k < NumRandom; k++) begin
      // Long stretches of back-to-back requests between gappy stretches.
      if ((k / 200) % 2 == 1) idle_gap();
      op = ($urandom_range(0, 19) == 0) ? OP_NONE : op_t'($urandom_range(0, 2));
      issue_request(op, random_operand(), random_operand(), 1'b0, 16'd0, 16'd0);
    end
    start <= 1'b0;

    drain = 0;
    while (pending_results.size() != 0 && drain < 10 * Latency) begin
      @(posedge clk);
      drain++;
    end
    repeat (Latency + 4) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/samdu_pkg.sv
rtl/samdu_step.sv
rtl/shift_add_multiply_divide_unit.sv
tb/tb.sv
